// ===== hw/rtl/mgcs_pkg.sv =====
package mgcs_pkg;

   // Field widths
   localparam int DataW     = 32;   // Q16.16 inputs, Q12.20 gains
   localparam int FracShift = 20;   // Q28.36 product down to Q28.16
   localparam int ProdW     = 2 * DataW - FracShift;
   localparam int DiffW     = DataW + 1;
   localparam int DeltaW    = ProdW + 5;
   localparam int CmdW      = 48;
   localparam int AppliedW  = 20;
   localparam int FrameW    = 5;
   localparam int MaxLanes  = 7;

   // Configuration port
   localparam int CsrIndexW = 4;
   localparam logic [CsrIndexW-1:0] RegReferenceGain = 4'd0;
   localparam logic [CsrIndexW-1:0] RegStateGain0    = 4'd1;

   // Limits
   localparam int DeltaLimit                 = 327680;   // 5.0 in Q16.16
   localparam logic [FrameW-1:0] SustainFrames = 5'd30;

   typedef logic signed [DataW-1:0]    data_type;
   typedef logic signed [ProdW-1:0]    prod_type;
   typedef logic signed [DiffW-1:0]    diff_type;
   typedef logic signed [DeltaW-1:0]   delta_type;
   typedef logic signed [CmdW-1:0]     cmd_type;
   typedef logic signed [AppliedW-1:0] applied_type;

   typedef enum logic [1:0] {
      SignNone = 2'b00,
      SignPos  = 2'b01,
      SignNeg  = 2'b11
   } sign_type;

endpackage

// ===== hw/rtl/mgcs_req_if.sv =====
interface mgcs_req_if;
   import mgcs_pkg::*;

   logic     valid;
   logic     ready;
   data_type state_0;
   data_type state_1;
   data_type state_2;
   data_type state_3;
   data_type state_4;
   data_type state_5;
   data_type state_6;
   data_type target;
   data_type disturbance;

   modport source (
      output valid, state_0, state_1, state_2, state_3, state_4, state_5, state_6,
             target, disturbance,
      input  ready
   );

   modport sink (
      input  valid, state_0, state_1, state_2, state_3, state_4, state_5, state_6,
             target, disturbance,
      output ready
   );
endinterface

// ===== hw/rtl/mgcs_rsp_if.sv =====
interface mgcs_rsp_if;
   import mgcs_pkg::*;

   logic        valid;
   logic        ready;
   cmd_type     command;
   applied_type applied_delta;
   logic        punch_fired;

   modport source (
      output valid, command, applied_delta, punch_fired,
      input  ready
   );

   modport sink (
      input  valid, command, applied_delta, punch_fired,
      output ready
   );
endinterface

// ===== hw/rtl/mgcs_lane.sv =====
module mgcs_lane (
   input  logic               clock,
   input  logic               load,
   input  mgcs_pkg::data_type gain,
   input  mgcs_pkg::data_type operand,
   output mgcs_pkg::prod_type product
);
   import mgcs_pkg::*;

   logic signed [2*DataW-1:0] full_product;
   prod_type                  product_ff;

   // Q12.20 x Q16.16, floor shift by dropping the low fraction bits
   assign full_product = gain * operand;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= full_product[2*DataW-1:FracShift];
      end
   end

   assign product = product_ff;
endmodule

// ===== hw/rtl/mgcs_merge.sv =====
module mgcs_merge #(
   parameter int NX = 7
) (
   input  logic                clock,
   input  logic                load,
   input  mgcs_pkg::prod_type  ref_product,
   input  mgcs_pkg::prod_type  lane_product [NX],
   input  mgcs_pkg::diff_type  dist_diff,
   output mgcs_pkg::delta_type delta
);
   import mgcs_pkg::*;

   localparam int TermN = MaxLanes + 2;

   delta_type terms [TermN];
   delta_type pair_sum [4];
   delta_type quad_sum [2];
   delta_type delta_in;
   delta_type delta_ff;

   // signed terms: +Kr*r, -(d - d_prev), -Kx_i*x_i; unused lanes add zero
   always_comb begin
      terms[0] = DeltaW'(ref_product);
      terms[1] = -DeltaW'(dist_diff);
      for (int i = 0; i < MaxLanes; i++) begin
         terms[i+2] = '0;
      end
      for (int i = 0; i < NX; i++) begin
         terms[i+2] = -DeltaW'(lane_product[i]);
      end
   end

   // balanced tree, four adders deep
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pair_sum[i] = terms[2*i] + terms[2*i+1];
      end
      quad_sum[0] = pair_sum[0] + pair_sum[1];
      quad_sum[1] = pair_sum[2] + pair_sum[3];
      delta_in    = (quad_sum[0] + quad_sum[1]) + terms[TermN-1];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta_in;
      end
   end

   assign delta = delta_ff;
endmodule

// ===== hw/rtl/mgcs_step.sv =====
module mgcs_step #(
   parameter int BACKLASH = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mgcs_pkg::delta_type   delta,
   output mgcs_pkg::cmd_type     command,
   output mgcs_pkg::applied_type applied_delta,
   output logic                  punch_fired
);
   import mgcs_pkg::*;

   localparam int NextW  = DeltaW + 1;
   localparam int BoostW = DeltaW + 1;
   localparam int SumW   = CmdW + 1;

   cmd_type          acc_ff, acc_in;
   applied_type      applied_ff, applied_in;
   logic             punch_ff, punch_in;
   sign_type         sign_ff, sign_in;
   logic [FrameW-1:0] frames_ff, frames_in;

   logic signed [NextW-1:0]  next_sum;
   logic signed [BoostW-1:0] boosted;
   logic signed [SumW-1:0]   acc_sum;
   sign_type                 next_sign;
   logic                     reversal;

   always_comb begin
      next_sum = NextW'(acc_ff) + NextW'(delta);
      if (next_sum > 0) begin
         next_sign = SignPos;
      end else if (next_sum < 0) begin
         next_sign = SignNeg;
      end else begin
         next_sign = SignNone;
      end

      reversal  = 1'b0;
      punch_in  = 1'b0;
      sign_in   = sign_ff;
      frames_in = frames_ff;
      boosted   = BoostW'(delta);

      if (BACKLASH > 0) begin
         reversal = (sign_ff != SignNone) && (next_sign != SignNone) &&
                    (next_sign != sign_ff);
         punch_in = reversal && (frames_ff >= SustainFrames);
         if (punch_in) begin
            if (next_sign == SignPos) begin
               boosted = BoostW'(delta) + BoostW'(BACKLASH);
            end else begin
               boosted = BoostW'(delta) - BoostW'(BACKLASH);
            end
         end
         if (reversal) begin
            frames_in = '0;
         end else if (next_sign != SignNone && frames_ff < SustainFrames) begin
            frames_in = frames_ff + 1'b1;
         end
         if (next_sign != SignNone) begin
            sign_in = next_sign;
         end
      end

      if (boosted > BoostW'(DeltaLimit)) begin
         applied_in = AppliedW'(DeltaLimit);
      end else if (boosted < -BoostW'(DeltaLimit)) begin
         applied_in = -AppliedW'(DeltaLimit);
      end else begin
         applied_in = boosted[AppliedW-1:0];
      end

      // saturate on signed overflow of the 48-bit accumulator
      acc_sum = SumW'(acc_ff) + SumW'(applied_in);
      if (acc_sum[SumW-1] != acc_sum[SumW-2]) begin
         acc_in = acc_sum[SumW-1] ? {1'b1, {(CmdW-1){1'b0}}} : {1'b0, {(CmdW-1){1'b1}}};
      end else begin
         acc_in = acc_sum[CmdW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         sign_ff   <= SignNone;
         frames_ff <= '0;
         punch_ff  <= 1'b0;
      end else if (load) begin
         acc_ff    <= acc_in;
         sign_ff   <= sign_in;
         frames_ff <= frames_in;
         punch_ff  <= punch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         applied_ff <= applied_in;
      end
   end

   assign command       = acc_ff;
   assign applied_delta = applied_ff;
   assign punch_fired   = punch_ff;
endmodule

// ===== hw/rtl/mpc_guide_command_step_unit.sv =====
// Pipeline: the request beat is registered in the lane, merge and step stages, in that order, before the response beat.
// Throughput: one beat per cycle while rsp is ready; the accumulator feeds back on itself within the
//   step stage, so consecutive frames never wait on each other.
// Reset: synchronous, active high; clears gains, accumulator, sign tracking,
//   previous disturbance and all stage valids.
module mpc_guide_command_step_unit #(
   parameter int NX       = 7,
   parameter int BACKLASH = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   mgcs_req_if.sink                           req,
   mgcs_rsp_if.source                         rsp,
   input  logic                               csr_write_enable,
   input  logic [mgcs_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [mgcs_pkg::DataW-1:0]         csr_write_data
);
   import mgcs_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers: Kr and the seven Kx gains.
   // Writes to an index past the last gain fall through untouched.
   // ---------------------------------------------------------------
   data_type reference_gain_ff;
   data_type state_gain_ff [MaxLanes];

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_gain_ff <= '0;
         for (int i = 0; i < MaxLanes; i++) begin
            state_gain_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         if (csr_index == RegReferenceGain) begin
            reference_gain_ff <= csr_write_data;
         end
         for (int i = 0; i < MaxLanes; i++) begin
            if (csr_index == RegStateGain0 + CsrIndexW'(i)) begin
               state_gain_ff[i] <= csr_write_data;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage control. Each stage moves when it is empty or its
   // successor moves, so bubbles fill even while rsp is stalled.
   // ---------------------------------------------------------------
   logic lane_valid_ff, merge_valid_ff, out_valid_ff;
   logic lane_move, merge_move, out_move;
   logic req_beat;

   assign out_move   = !out_valid_ff || rsp.ready;
   assign merge_move = !merge_valid_ff || out_move;
   assign lane_move  = !lane_valid_ff || merge_move;
   assign req.ready  = lane_move;
   assign req_beat   = req.valid && lane_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff  <= 1'b0;
         merge_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (lane_move) begin
            lane_valid_ff <= req.valid;
         end
         if (merge_move) begin
            merge_valid_ff <= lane_valid_ff;
         end
         if (out_move) begin
            out_valid_ff <= merge_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Disturbance change, taken in request order alongside the lanes.
   // ---------------------------------------------------------------
   data_type prev_disturbance_ff;
   diff_type dist_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_disturbance_ff <= '0;
      end else if (req_beat) begin
         prev_disturbance_ff <= req.disturbance;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         dist_diff_ff <= DiffW'(req.disturbance) - DiffW'(prev_disturbance_ff);
      end
   end

   // ---------------------------------------------------------------
   // Lanes: one multiplier for Kr*target and one per used state element.
   // Elements at or above NX are never multiplied.
   // ---------------------------------------------------------------
   data_type state_vec [MaxLanes];
   prod_type lane_product [NX];
   prod_type ref_product;

   assign state_vec[0] = req.state_0;
   assign state_vec[1] = req.state_1;
   assign state_vec[2] = req.state_2;
   assign state_vec[3] = req.state_3;
   assign state_vec[4] = req.state_4;
   assign state_vec[5] = req.state_5;
   assign state_vec[6] = req.state_6;

   mgcs_lane u_ref_lane (
      .clock   (clock),
      .load    (req_beat),
      .gain    (reference_gain_ff),
      .operand (req.target),
      .product (ref_product)
   );

   for (genvar g = 0; g < NX; g++) begin : g_lane
      mgcs_lane u_lane (
         .clock   (clock),
         .load    (req_beat),
         .gain    (state_gain_ff[g]),
         .operand (state_vec[g]),
         .product (lane_product[g])
      );
   end

   // ---------------------------------------------------------------
   // Merge: raw delta = Kr*r - sum(Kx*x) - (d - d_prev)
   // ---------------------------------------------------------------
   delta_type raw_delta;

   mgcs_merge #(
      .NX (NX)
   ) u_merge (
      .clock        (clock),
      .load         (merge_move && lane_valid_ff),
      .ref_product  (ref_product),
      .lane_product (lane_product),
      .dist_diff    (dist_diff_ff),
      .delta        (raw_delta)
   );

   // ---------------------------------------------------------------
   // Step: backlash punch, clamp to +/-5.0, saturating accumulate.
   // Its registers double as the response payload.
   // ---------------------------------------------------------------
   logic out_load;

   assign out_load = out_move && merge_valid_ff;

   mgcs_step #(
      .BACKLASH (BACKLASH)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .load          (out_load),
      .delta         (raw_delta),
      .command       (rsp.command),
      .applied_delta (rsp.applied_delta),
      .punch_fired   (rsp.punch_fired)
   );

   assign rsp.valid = out_valid_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_delta_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.applied_delta <= AppliedW'(DeltaLimit)) &&
                    (rsp.applied_delta >= -AppliedW'(DeltaLimit)))
      else $error("applied delta beyond clamp");

   a_no_punch_without_backlash: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (BACKLASH == 0)) |-> !rsp.punch_fired)
      else $error("punch fired with zero backlash");

   a_beat_enters_lanes: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> lane_valid_ff)
      else $error("accepted beat lost at lane stage");

   a_command_holds: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(rsp.command))
      else $error("command moved without a step");
endmodule
